// ----- rtl/sxlt_pkg.sv -----
package sxlt_pkg;

    // Widths of the request and response fields.
    localparam int CLIENT_W = 3;
    localparam int SLOT_W   = 3;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 2;

    // Width of a per-slot shared holder count.
    localparam int HOLD_W = 4;

    // Number of client identities that the client field can name.
    localparam int CLIENT_IDS = 1 << CLIENT_W;

    // Request operation codes.
    typedef enum logic {
        OP_RANGE   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    // One request word as held in the input register.
    typedef struct packed {
        op_t                operation;
        logic [CLIENT_W-1:0] client;
        logic               bound;
        logic [SLOT_W-1:0]  first_slot;
        logic [COUNT_W-1:0] slot_count;
        logic               do_lock;
        logic               want_shared;
    } req_t;

    // Outcome of evaluating one request.
    typedef struct packed {
        status_t status;
        logic    wr_client;
    } res_t;

endpackage

// ----- rtl/sxlt_req_if.sv -----
interface sxlt_req_if;
    import sxlt_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [CLIENT_W-1:0] client;
    logic                bound;
    logic [SLOT_W-1:0]   first_slot;
    logic [COUNT_W-1:0]  slot_count;
    logic                do_lock;
    logic                want_shared;

    modport source (
        output valid, operation, client, bound, first_slot, slot_count, do_lock,
               want_shared,
        input  ready
    );

    modport sink (
        input  valid, operation, client, bound, first_slot, slot_count, do_lock,
               want_shared,
        output ready
    );
endinterface

// ----- rtl/sxlt_rsp_if.sv -----
interface sxlt_rsp_if;
    import sxlt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, status,
        input  ready
    );

    modport sink (
        input  valid, status,
        output ready
    );
endinterface

// ----- rtl/shared_exclusive_slot_lock_table.sv -----
// Shared/exclusive lock table over NUM_SLOTS slots for up to NUM_CLIENTS clients. Each request
// word is held in the input register and then passes through the slot compare and update logic
// into the status register, which offers its status word. Every slot of a range is checked and
// updated at once as a bit mask, so a new request word is accepted in every cycle while the
// response side keeps taking status words; the table state seen by a request already includes
// every earlier request. A stalled response holds the status register and, one word later, the
// input register.
module shared_exclusive_slot_lock_table #(
    parameter int NUM_SLOTS   = 8,
    parameter int NUM_CLIENTS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    sxlt_req_if.sink          req,
    sxlt_rsp_if.source        rsp
);
    import sxlt_pkg::*;

    // Only client numbers that the client field can carry need a mask entry.
    localparam int CLIENT_ENTRIES = (NUM_CLIENTS < CLIENT_IDS) ? NUM_CLIENTS : CLIENT_IDS;
    localparam int CIDX_W         = $clog2(CLIENT_ENTRIES);

    logic                                 s1_valid_reg;
    logic                                 s1_valid_next;
    req_t                                 s1_req_reg;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    status_t                              status_reg;
    logic                                 s1_advance;
    logic                                 commit;
    logic [CIDX_W-1:0]                    cidx;
    logic                                 cidx_ok;
    logic [NUM_SLOTS-1:0]                 my_shared;
    logic [NUM_SLOTS-1:0]                 my_excl;

    logic [NUM_SLOTS-1:0][HOLD_W-1:0]     holders_reg;
    logic [NUM_SLOTS-1:0]                 excl_valid_reg;
    logic [NUM_SLOTS-1:0][CLIENT_W-1:0]   excl_owner_reg;
    logic [CLIENT_ENTRIES-1:0][NUM_SLOTS-1:0] client_shared_reg;
    logic [CLIENT_ENTRIES-1:0][NUM_SLOTS-1:0] client_excl_reg;

    logic [NUM_SLOTS-1:0][HOLD_W-1:0]     holders_next;
    logic [NUM_SLOTS-1:0]                 excl_valid_next;
    logic [NUM_SLOTS-1:0][CLIENT_W-1:0]   excl_owner_next;
    logic [NUM_SLOTS-1:0]                 my_shared_next;
    logic [NUM_SLOTS-1:0]                 my_excl_next;
    res_t                                 res;

    // Handshake: the held request moves on when the status register is free or being emptied.
    assign s1_advance = !out_valid_reg || rsp.ready;
    assign commit     = s1_valid_reg && s1_advance;
    assign req.ready  = !s1_valid_reg || s1_advance;

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = status_reg;

    // The requester's own masks; a client without an entry reads as holding nothing.
    assign cidx      = s1_req_reg.client[CIDX_W-1:0];
    assign cidx_ok   = 32'(s1_req_reg.client) < CLIENT_ENTRIES;
    assign my_shared = cidx_ok ? client_shared_reg[cidx] : '0;
    assign my_excl   = cidx_ok ? client_excl_reg[cidx] : '0;

    sxlt_eval #(
        .NUM_SLOTS   (NUM_SLOTS),
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_eval (
        .req             (s1_req_reg),
        .holders         (holders_reg),
        .excl_valid      (excl_valid_reg),
        .excl_owner      (excl_owner_reg),
        .my_shared       (my_shared),
        .my_excl         (my_excl),
        .holders_next    (holders_next),
        .excl_valid_next (excl_valid_next),
        .excl_owner_next (excl_owner_next),
        .my_shared_next  (my_shared_next),
        .my_excl_next    (my_excl_next),
        .res             (res)
    );

    // Valid flags of the input and status registers.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req.valid && req.ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register: captures one request word.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_req_reg.operation   <= op_t'(req.operation);
            s1_req_reg.client      <= req.client;
            s1_req_reg.bound       <= req.bound;
            s1_req_reg.first_slot  <= req.first_slot;
            s1_req_reg.slot_count  <= req.slot_count;
            s1_req_reg.do_lock     <= req.do_lock;
            s1_req_reg.want_shared <= req.want_shared;
        end
    end

    // Status register.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg <= res.status;
        end
    end

    // Lock table state, updated as each request commits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holders_reg       <= '0;
            excl_valid_reg    <= '0;
            excl_owner_reg    <= '0;
            client_shared_reg <= '0;
            client_excl_reg   <= '0;
        end
        else if (commit)
        begin
            holders_reg    <= holders_next;
            excl_valid_reg <= excl_valid_next;
            excl_owner_reg <= excl_owner_next;
            if (res.wr_client)
            begin
                client_shared_reg[cidx] <= my_shared_next;
                client_excl_reg[cidx]   <= my_excl_next;
            end
        end
    end
endmodule

// ----- rtl/sxlt_eval.sv -----
module sxlt_eval #(
    parameter int NUM_SLOTS  = 8,
    parameter int NUM_CLIENTS = 8
) (
    input  sxlt_pkg::req_t                              req,
    input  logic [NUM_SLOTS-1:0][sxlt_pkg::HOLD_W-1:0]   holders,
    input  logic [NUM_SLOTS-1:0]                        excl_valid,
    input  logic [NUM_SLOTS-1:0][sxlt_pkg::CLIENT_W-1:0] excl_owner,
    input  logic [NUM_SLOTS-1:0]                        my_shared,
    input  logic [NUM_SLOTS-1:0]                        my_excl,
    output logic [NUM_SLOTS-1:0][sxlt_pkg::HOLD_W-1:0]   holders_next,
    output logic [NUM_SLOTS-1:0]                        excl_valid_next,
    output logic [NUM_SLOTS-1:0][sxlt_pkg::CLIENT_W-1:0] excl_owner_next,
    output logic [NUM_SLOTS-1:0]                        my_shared_next,
    output logic [NUM_SLOTS-1:0]                        my_excl_next,
    output sxlt_pkg::res_t                              res
);
    import sxlt_pkg::*;

    localparam int END_W = COUNT_W + 1;

    logic [END_W-1:0]     range_end;
    logic                 known;
    logic                 bad_range;
    logic                 busy;
    logic [NUM_SLOTS-1:0] in_range;
    logic [NUM_SLOTS-1:0] own_excl;
    logic [NUM_SLOTS-1:0] other_excl;
    logic [NUM_SLOTS-1:0] slot_busy;

    // Range bounds and client validity.
    assign range_end = END_W'(req.first_slot) + END_W'(req.slot_count);
    assign known     = req.bound && (32'(req.client) < NUM_CLIENTS);
    assign bad_range = (req.slot_count == '0) || (32'(range_end) > NUM_SLOTS);

    // Per-slot range membership, ownership and conflict, all in parallel.
    for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
        assign in_range[s]   = (32'(req.first_slot) <= s) && (s < 32'(range_end));
        assign own_excl[s]   = excl_valid[s] && (excl_owner[s] == req.client);
        assign other_excl[s] = excl_valid[s] && (excl_owner[s] != req.client);
        assign slot_busy[s]  = other_excl[s] ||
                               (!req.want_shared && (holders[s] > HOLD_W'(my_shared[s])));
    end

    // A lock is refused if any slot of the range conflicts.
    assign busy = |(in_range & slot_busy);

    // Status and next table state.
    always_comb
    begin
        holders_next    = holders;
        excl_valid_next = excl_valid;
        excl_owner_next = excl_owner;
        my_shared_next  = my_shared;
        my_excl_next    = my_excl;
        res.status      = ST_OK;
        res.wr_client   = 1'b0;

        if (req.operation == OP_RELEASE)
        begin
            // Release drops every hold of a known client and always answers ok.
            if (known)
            begin
                res.wr_client  = 1'b1;
                my_shared_next = '0;
                my_excl_next   = '0;
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    if (my_shared[s] && (holders[s] != '0))
                    begin
                        holders_next[s] = holders[s] - HOLD_W'(1);
                    end
                    if (my_excl[s] && own_excl[s])
                    begin
                        excl_valid_next[s] = 1'b0;
                        excl_owner_next[s] = '0;
                    end
                end
            end
        end
        else if (!known || bad_range)
        begin
            res.status = ST_ERR;
        end
        else if (req.do_lock && busy)
        begin
            res.status = ST_BUSY;
        end
        else
        begin
            res.wr_client = 1'b1;
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                if (in_range[s])
                begin
                    if (req.do_lock && req.want_shared)
                    begin
                        // A slot already held shared is not counted twice.
                        if (!my_shared[s])
                        begin
                            my_shared_next[s] = 1'b1;
                            holders_next[s]   = holders[s] + HOLD_W'(1);
                        end
                    end
                    else if (req.do_lock)
                    begin
                        my_excl_next[s]    = 1'b1;
                        excl_valid_next[s] = 1'b1;
                        excl_owner_next[s] = req.client;
                    end
                    else if (req.want_shared)
                    begin
                        if (my_shared[s])
                        begin
                            my_shared_next[s] = 1'b0;
                            if (holders[s] != '0)
                            begin
                                holders_next[s] = holders[s] - HOLD_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        // The owner is cleared only when it is this client.
                        if (my_excl[s])
                        begin
                            my_excl_next[s] = 1'b0;
                            if (own_excl[s])
                            begin
                                excl_valid_next[s] = 1'b0;
                                excl_owner_next[s] = '0;
                            end
                        end
                    end
                end
            end
        end
    end
endmodule

// ----- rtl/sxlt_check.sv -----
module sxlt_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          req_operation,
    input logic                          req_bound,
    input logic [sxlt_pkg::COUNT_W-1:0]  req_slot_count,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [sxlt_pkg::STATUS_W-1:0] rsp_status
);
    import sxlt_pkg::*;

    logic req_acc;

    assign req_acc = req_valid && req_ready;

    // Every accepted request word is followed by a status word on offer.
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> ##1 rsp_valid)
        else $error("no status word after an accepted request");

    // A release always answers ok.
    a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && (req_operation == OP_RELEASE)) ##1 (rsp_ready || !rsp_valid)
        |=> rsp_valid && (rsp_status == ST_OK))
        else $error("release did not answer ok");

    // A range request with an empty range or an unbound client is an error.
    a_range_err: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && (req_operation == OP_RANGE) &&
         (!req_bound || (req_slot_count == '0))) ##1 (rsp_ready || !rsp_valid)
        |=> rsp_valid && (rsp_status == ST_ERR))
        else $error("bad range request did not answer with an error");

    // A stalled status word holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_status))
        else $error("stalled status word changed");
endmodule

bind shared_exclusive_slot_lock_table sxlt_check u_sxlt_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_operation  (req.operation),
    .req_bound      (req.bound),
    .req_slot_count (req.slot_count),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status)
);
